### rtl/core/slope_limiter_unit_macros.svh
// Assertion macros shared by the slope limiter checker.
`ifndef SLOPE_LIMITER_UNIT_MACROS_SVH
`define SLOPE_LIMITER_UNIT_MACROS_SVH

// Property checked only outside reset.
`define SLU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included.
`define SLU_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/slu_pkg.sv
// Shared types and constants of the slope limiter.
package slu_pkg;

   localparam int OUT_WIDTH = 19;
   localparam int MAG_WIDTH = 32;
   localparam int NUM_WIDTH = 64;

   // Limiter select codes carried in req_tuser.
   localparam logic [1:0] CMD_MINMOD   = 2'd0;
   localparam logic [1:0] CMD_SUPERBEE = 2'd1;
   localparam logic [1:0] CMD_VANLEER  = 2'd2;
   localparam logic [1:0] CMD_ALBADA   = 2'd3;

   // Fixed result for items that skip the divider.
   typedef enum logic [1:0] {
      RES_ZERO = 2'd0,
      RES_ONE  = 2'd1,
      RES_TWO  = 2'd2
   } res_code_type;

   // Sideband that travels with each item down the divider chain.
   typedef struct packed {
      logic         valid;
      logic         neg;
      logic         bypass;
      res_code_type code;
   } side_type;

endpackage

### rtl/core/slu_div_cell.sv
// One restoring-division cell: one quotient bit, registered.
module slu_div_cell #(
   parameter int QW    = 17,
   parameter bit SHIFT = 1'b1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  slu_pkg::side_type                  side_in,
   input  logic [slu_pkg::NUM_WIDTH-1:0]      rem_in,
   input  logic [slu_pkg::NUM_WIDTH-1:0]      den_in,
   input  logic [QW-1:0]                      quo_in,
   output slu_pkg::side_type                  side_out,
   output logic [slu_pkg::NUM_WIDTH-1:0]      rem_out,
   output logic [slu_pkg::NUM_WIDTH-1:0]      den_out,
   output logic [QW-1:0]                      quo_out
);
   logic [slu_pkg::NUM_WIDTH:0]   trial;
   logic [slu_pkg::NUM_WIDTH:0]   diff;
   logic                          ge;
   slu_pkg::side_type             side_ff;
   logic [slu_pkg::NUM_WIDTH-1:0] rem_ff, rem_in_next;
   logic [slu_pkg::NUM_WIDTH-1:0] den_ff;
   logic [QW-1:0]                 quo_ff, quo_in_next;

   // shift, compare, subtract
   always_comb begin
      trial = SHIFT ? {rem_in, 1'b0} : {1'b0, rem_in};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
      rem_in_next = ge ? diff[slu_pkg::NUM_WIDTH-1:0] : trial[slu_pkg::NUM_WIDTH-1:0];
      quo_in_next = {quo_in[QW-2:0], ge};
   end

   // valid flag is reset, data fields only follow the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (advance) begin
         side_ff.valid <= side_in.valid;
      end
      if (advance) begin
         side_ff.neg    <= side_in.neg;
         side_ff.bypass <= side_in.bypass;
         side_ff.code   <= side_in.code;
         rem_ff         <= rem_in_next;
         den_ff         <= den_in;
         quo_ff         <= quo_in_next;
      end
   end

   assign side_out = side_ff;
   assign rem_out  = rem_ff;
   assign den_out  = den_ff;
   assign quo_out  = quo_ff;
endmodule

### rtl/core/slope_limiter_unit.sv
// Slope limiter top level: setup stages, divider cell chain, output register.
// Usage:
//  - req channel: req_tdata holds plus_slope (bits 31:0) and minus_slope
//    (bits 63:32), both signed Q16.16; req_tuser selects the limiter
//    (0 minmod, 1 superbee, 2 van Leer, 3 van Albada).
//  - rsp channel: rsp_tdata[18:0] holds the signed limiter value with
//    FRAC_BITS fraction bits, truncated toward zero.
//  - Pipeline: the input transfer edge loads the magnitude and product stage,
//    then come one stage for operand selection, FRAC_BITS + 1 divider cells
//    (one quotient bit each) and one output stage, which drives rsp_tvalid.
//  - Throughput: one item per cycle while the receiver does not stall; the cell chain holds one item per cell.
//  - When the receiver stalls, the whole pipeline holds and req_tready
//    falls while a result waits; a waiting result keeps its data.
//  - Reset clears all valid flags; no item is in flight afterwards.
module slope_limiter_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // plus_slope[31:0], minus_slope[63:32]
   input  logic [1:0]  req_tuser,  // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // limiter_value[18:0], zero fill [23:19]
);
   localparam int QW    = FRAC_BITS + 1;
   localparam int CELLS = FRAC_BITS + 1;
   localparam int MW    = slu_pkg::MAG_WIDTH;
   localparam int NW    = slu_pkg::NUM_WIDTH;

   logic advance;
   logic [MW-1:0] p, m, a, b;
   logic zero, opp;

   // stage 1 registers
   logic          s1_valid_ff;
   logic [1:0]    s1_cmd_ff;
   logic [MW-1:0] s1_a_ff, s1_b_ff;
   logic [NW-1:0] s1_aa_ff, s1_ab_ff, s1_bb_ff;
   logic          s1_zero_ff, s1_opp_ff;

   // stage 2 selection
   slu_pkg::side_type side_in;
   logic [NW-1:0]     num_in, den_in;
   logic [MW:0]       a2, b2, asum;
   slu_pkg::side_type s2_side_ff;
   logic [NW-1:0]     s2_num_ff, s2_den_ff;

   // chain
   slu_pkg::side_type cside [CELLS+1];
   logic [NW-1:0]     crem  [CELLS+1];
   logic [NW-1:0]     cden  [CELLS+1];
   logic [QW-1:0]     cquo  [CELLS+1];

   // output
   logic signed [NW-1:0] value;
   logic                 rsp_valid_ff;
   logic [slu_pkg::OUT_WIDTH-1:0] rsp_value_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // magnitudes and sign relation
   always_comb begin
      p    = req_tdata[31:0];
      m    = req_tdata[63:32];
      a    = p[MW-1] ? (~p + 1'b1) : p;
      b    = m[MW-1] ? (~m + 1'b1) : m;
      zero = (a == '0) || (b == '0);
      opp  = !zero && (p[MW-1] != m[MW-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // stage 1 data: operands, flags and the products for van Albada, one multiplier each
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff  <= req_tuser;
         s1_a_ff    <= a;
         s1_b_ff    <= b;
         s1_aa_ff   <= a * a;
         s1_ab_ff   <= a * b;
         s1_bb_ff   <= b * b;
         s1_zero_ff <= zero;
         s1_opp_ff  <= opp;
      end
   end

   // operand selection and special cases
   always_comb begin
      a2   = {s1_a_ff, 1'b0};
      b2   = {s1_b_ff, 1'b0};
      asum = {1'b0, s1_a_ff} + {1'b0, s1_b_ff};
      side_in.valid  = s1_valid_ff;
      side_in.neg    = 1'b0;
      side_in.bypass = 1'b1;
      side_in.code   = slu_pkg::RES_ZERO;
      num_in = '0;
      den_in = {{(NW-1){1'b0}}, 1'b1};
      case (s1_cmd_ff)
         slu_pkg::CMD_MINMOD: begin
            if (s1_a_ff == '0 || s1_opp_ff) begin
               side_in.code = slu_pkg::RES_ZERO;
            end else if (s1_a_ff >= s1_b_ff) begin
               side_in.code = slu_pkg::RES_ONE;
            end else begin
               side_in.bypass = 1'b0;
               num_in = NW'(s1_a_ff);
               den_in = NW'(s1_b_ff);
            end
         end
         slu_pkg::CMD_SUPERBEE: begin
            if (s1_zero_ff || s1_opp_ff) begin
               side_in.code = slu_pkg::RES_ZERO;
            end else if (a2 < {1'b0, s1_b_ff}) begin
               side_in.bypass = 1'b0;
               num_in = NW'(a2);
               den_in = NW'(s1_b_ff);
            end else if (s1_a_ff < s1_b_ff) begin
               side_in.code = slu_pkg::RES_ONE;
            end else if ({1'b0, s1_a_ff} < b2) begin
               side_in.bypass = 1'b0;
               num_in = NW'(s1_a_ff);
               den_in = NW'(s1_b_ff);
            end else begin
               side_in.code = slu_pkg::RES_TWO;
            end
         end
         slu_pkg::CMD_VANLEER: begin
            if (s1_zero_ff || s1_opp_ff) begin
               side_in.code = slu_pkg::RES_ZERO;
            end else begin
               side_in.bypass = 1'b0;
               num_in = NW'(a2);
               den_in = NW'(asum);
            end
         end
         default: begin
            if (s1_zero_ff || (s1_opp_ff && s1_a_ff > s1_b_ff)) begin
               side_in.code = slu_pkg::RES_ZERO;
            end else begin
               side_in.bypass = 1'b0;
               side_in.neg    = s1_opp_ff;
               den_in = s1_aa_ff + s1_bb_ff;
               num_in = s1_opp_ff ? (s1_ab_ff - s1_aa_ff) : (s1_aa_ff + s1_ab_ff);
            end
         end
      endcase
   end

   // stage 2 register: only the valid flag is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_side_ff.valid <= side_in.valid;
      end
      if (advance) begin
         s2_side_ff.neg    <= side_in.neg;
         s2_side_ff.bypass <= side_in.bypass;
         s2_side_ff.code   <= side_in.code;
         s2_num_ff         <= num_in;
         s2_den_ff         <= den_in;
      end
   end

   assign cside[0] = s2_side_ff;
   assign crem[0]  = s2_num_ff;
   assign cden[0]  = s2_den_ff;
   assign cquo[0]  = '0;

   // divider chain: integer bit first, then one fraction bit per cell
   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      slu_div_cell #(
         .QW    (QW),
         .SHIFT ((k == 0) ? 1'b0 : 1'b1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .side_in  (cside[k]),
         .rem_in   (crem[k]),
         .den_in   (cden[k]),
         .quo_in   (cquo[k]),
         .side_out (cside[k+1]),
         .rem_out  (crem[k+1]),
         .den_out  (cden[k+1]),
         .quo_out  (cquo[k+1])
      );
   end

   // final value and sign
   always_comb begin
      value = '0;
      if (cside[CELLS].bypass) begin
         case (cside[CELLS].code)
            slu_pkg::RES_ONE: value = NW'(1) << FRAC_BITS;
            slu_pkg::RES_TWO: value = NW'(2) << FRAC_BITS;
            default:          value = '0;
         endcase
      end else if (cside[CELLS].neg) begin
         value = -$signed(NW'(cquo[CELLS]));
      end else begin
         value = $signed(NW'(cquo[CELLS]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cside[CELLS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= value[slu_pkg::OUT_WIDTH-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_value_ff};
endmodule

### rtl/core/slu_checker.sv
// Port-level checker for the slope limiter, bound to the top level.
`include "slope_limiter_unit_macros.svh"

module slu_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   // no result right after reset
   `SLU_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result valid after reset")

   // input side moves exactly when the output register can move
   `SLU_ASSERT(a_ready_link, req_tready == (!rsp_tvalid || rsp_tready), "ready mismatch")

   // a stalled result keeps its data
   `SLU_ASSERT(a_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled result changed")

   // fill bits stay zero
   `SLU_ASSERT(a_pad, rsp_tvalid |-> (rsp_tdata[23:19] == 5'b0), "tdata fill not zero")
endmodule

bind slope_limiter_unit slu_port_checker u_slu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
